// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define BDA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bda assertion failed");

// Same-cycle implication, disabled while reset is high.
`define BDA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   `BDA_ASSERT(label, clk, rst, (ante) |-> (cons))

`endif

// ----- hw/rtl/bda_pkg.sv -----
// Types and constants of the button debounce and auto-repeat block.
// No dependencies; imported by every module of the block.
package bda_pkg;

   localparam int RAW_W      = 5;
   localparam int IDX_W      = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [15:0] POLL_INTERVAL_RST  = 16'd5000;
   localparam logic [7:0]  DEBOUNCE_LIMIT_RST = 8'd10;
   localparam logic [7:0]  REPEAT_INITIAL_RST = 8'd40;
   localparam logic [7:0]  REPEAT_NEXT_RST    = 8'd20;

   typedef enum logic [1:0] {
      OP_POLL  = 2'd0,
      OP_GET   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_LEVEL = 2'd3
   } bda_op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLL_INTERVAL  = 2'd0,
      CSR_DEBOUNCE_LIMIT = 2'd1,
      CSR_REPEAT_INITIAL = 2'd2,
      CSR_REPEAT_NEXT    = 2'd3
   } bda_csr_type;

   typedef struct packed {
      bda_op_type       opcode;
      logic [31:0]      now_us;
      logic [RAW_W-1:0] raw_levels;
      logic [IDX_W-1:0] button_index;
   } bda_req_type;

   typedef struct packed {
      logic             answer_bit;
      logic             poll_taken;
      logic [RAW_W-1:0] held_levels;
      logic [RAW_W-1:0] pending_flags;
   } bda_rsp_type;

   typedef struct packed {
      logic [15:0] poll_interval_us;
      logic [7:0]  debounce_limit;
      logic [7:0]  repeat_initial;
      logic [7:0]  repeat_next;
   } bda_cfg_type;

   // Per-button commands for one accepted transaction
   typedef struct packed {
      logic poll;
      logic get_clr;
      logic clr_all;
   } bda_lane_ctl_type;

   // Per-button state before and after the transaction
   typedef struct packed {
      logic stable_cur;
      logic flag_cur;
      logic stable_nxt;
      logic flag_nxt;
   } bda_lane_stat_type;

endpackage

// ----- hw/rtl/bda_lane.sv -----
// One button's debounce counter, auto-repeat countdown and pressed flag.
// Depends on bda_pkg.
module bda_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  bda_pkg::bda_cfg_type      cfg,
   input  bda_pkg::bda_lane_ctl_type ctl,
   input  logic                      level,
   output bda_pkg::bda_lane_stat_type stat
);
   import bda_pkg::*;

   logic       stable_ff,   stable_in;
   logic       flag_ff,     flag_in;
   logic [7:0] mismatch_ff, mismatch_in;
   logic [7:0] repeat_ff,   repeat_in;
   logic [7:0] repeat_dec;

   assign repeat_dec = repeat_ff - 8'd1;

   // Work out the state after this transaction
   always_comb begin
      stable_in   = stable_ff;
      flag_in     = flag_ff;
      mismatch_in = mismatch_ff;
      repeat_in   = repeat_ff;
      if (ctl.poll) begin
         if (level == stable_ff) begin
            mismatch_in = 8'd0;
            // Count down while held, re-arm the flag on reaching zero
            if (!level) begin
               if (repeat_dec == 8'd0) begin
                  repeat_in = cfg.repeat_next;
                  flag_in   = 1'b1;
               end else begin
                  repeat_in = repeat_dec;
               end
            end
         end else if (mismatch_ff > cfg.debounce_limit) begin
            // Accept the new level
            mismatch_in = 8'd0;
            repeat_in   = cfg.repeat_initial;
            stable_in   = level;
            if (!level) begin
               flag_in = 1'b1;
            end
         end else begin
            mismatch_in = mismatch_ff + 8'd1;
         end
      end
      if (ctl.get_clr || ctl.clr_all) begin
         flag_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff   <= 1'b0;
         flag_ff     <= 1'b0;
         mismatch_ff <= 8'd0;
         repeat_ff   <= 8'd0;
      end else begin
         stable_ff   <= stable_in;
         flag_ff     <= flag_in;
         mismatch_ff <= mismatch_in;
         repeat_ff   <= repeat_in;
      end
   end

   assign stat.stable_cur = stable_ff;
   assign stat.flag_cur   = flag_ff;
   assign stat.stable_nxt = stable_in;
   assign stat.flag_nxt   = flag_in;

endmodule

// ----- hw/rtl/button_debounce_autorepeat_core.sv -----
// Button debouncer with auto-repeat, top level. Depends on bda_pkg and bda_lane.
// Throughput: one transaction per cycle while req_stall is low. A result is
// registered in the output stage when accepted; the per-button update is one pass of
// compare and counter logic, and a two-entry output stage absorbs one stalled result.
// Reset (synchronous): all button state and the poll timestamp clear, settings
// return to 5000 us, 10, 40 and 20, and the output stage empties.
module button_debounce_autorepeat_core #(
   parameter int BUTTON_COUNT = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  bda_pkg::bda_req_type                 req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output bda_pkg::bda_rsp_type                 rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [bda_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bda_pkg::CSR_DATA_W-1:0]       csr_wr_data
);
   import bda_pkg::*;

   bda_cfg_type       cfg_ff;
   logic [31:0]       last_poll_ff, last_poll_in;
   bda_rsp_type       rsp_ff, skid_ff, rsp_new;
   logic              rsp_valid_ff, skid_valid_ff;
   logic              accept, pop, poll_ok;
   logic [31:0]       elapsed;
   bda_lane_ctl_type  lane_ctl  [BUTTON_COUNT];
   bda_lane_stat_type lane_stat [BUTTON_COUNT];
   logic [BUTTON_COUNT-1:0] sel, flag_cur_v, pressed_cur_v;
   logic [RAW_W-1:0]  held_out, flags_out;

   assign accept = req_valid && !skid_valid_ff;
   assign pop    = rsp_valid_ff && !rsp_stall;

   // Poll interval check with wrapping subtraction
   assign elapsed = req_data.now_us - last_poll_ff;
   assign poll_ok = accept && (req_data.opcode == OP_POLL) &&
                    (elapsed >= {16'd0, cfg_ff.poll_interval_us});
   assign last_poll_in = poll_ok ? req_data.now_us : last_poll_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poll_interval_us <= POLL_INTERVAL_RST;
         cfg_ff.debounce_limit   <= DEBOUNCE_LIMIT_RST;
         cfg_ff.repeat_initial   <= REPEAT_INITIAL_RST;
         cfg_ff.repeat_next      <= REPEAT_NEXT_RST;
      end else if (csr_wr_en) begin
         unique case (bda_csr_type'(csr_index))
            CSR_POLL_INTERVAL:  cfg_ff.poll_interval_us <= csr_wr_data;
            CSR_DEBOUNCE_LIMIT: cfg_ff.debounce_limit   <= csr_wr_data[7:0];
            CSR_REPEAT_INITIAL: cfg_ff.repeat_initial   <= csr_wr_data[7:0];
            CSR_REPEAT_NEXT:    cfg_ff.repeat_next      <= csr_wr_data[7:0];
            default:            cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_poll_ff <= 32'd0;
      end else begin
         last_poll_ff <= last_poll_in;
      end
   end

   // Button lanes
   for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
      logic level;
      if (i < RAW_W) begin : g_raw
         assign level = req_data.raw_levels[i];
      end else begin : g_tied
         assign level = 1'b0;
      end
      if (i < (2 ** IDX_W)) begin : g_sel
         assign sel[i] = (req_data.button_index == IDX_W'(i));
      end else begin : g_nosel
         assign sel[i] = 1'b0;
      end
      assign lane_ctl[i].poll    = poll_ok;
      assign lane_ctl[i].get_clr = accept && (req_data.opcode == OP_GET) && sel[i];
      assign lane_ctl[i].clr_all = accept && (req_data.opcode == OP_CLEAR);
      assign flag_cur_v[i]    = lane_stat[i].flag_cur;
      assign pressed_cur_v[i] = !lane_stat[i].stable_cur;

      bda_lane u_lane (
         .clock (clock),
         .reset (reset),
         .cfg   (cfg_ff),
         .ctl   (lane_ctl[i]),
         .level (level),
         .stat  (lane_stat[i])
      );
   end

   // Report the low buttons only
   for (genvar b = 0; b < RAW_W; b++) begin : g_out
      if (b < BUTTON_COUNT) begin : g_used
         assign held_out[b]  = !lane_stat[b].stable_nxt;
         assign flags_out[b] = lane_stat[b].flag_nxt;
      end else begin : g_unused
         assign held_out[b]  = 1'b0;
         assign flags_out[b] = 1'b0;
      end
   end

   // Assemble the result of this transaction
   always_comb begin
      rsp_new.poll_taken    = poll_ok;
      rsp_new.held_levels   = held_out;
      rsp_new.pending_flags = flags_out;
      case (req_data.opcode)
         OP_GET:   rsp_new.answer_bit = |(sel & flag_cur_v);
         OP_LEVEL: rsp_new.answer_bit = |(sel & pressed_cur_v);
         default:  rsp_new.answer_bit = 1'b0;
      endcase
   end

   // Output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            rsp_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (rsp_valid_ff && !pop) begin
            skid_ff       <= rsp_new;
            skid_valid_ff <= 1'b1;
         end else begin
            rsp_ff       <= rsp_new;
            rsp_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hw/rtl/bda_checker.sv -----
// Port-level checks for the button debounce block, bound to its top level.
// Depends on bda_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bda_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input bda_pkg::bda_rsp_type rsp_data
);
   import bda_pkg::*;

   logic both_set;

   assign both_set = rsp_data.answer_bit && rsp_data.poll_taken;

   // A poll never answers, a get or level read never polls
   `BDA_ASSERT_IMPLIES(a_answer_poll_excl, clock, reset, rsp_valid, !both_set)

   // An empty output never back-pressures the input
   `BDA_ASSERT_IMPLIES(a_no_stall_when_empty, clock, reset, !rsp_valid, !req_stall)

   // Leaving reset, the output stage is empty
   `BDA_ASSERT_IMPLIES(a_reset_empty, clock, reset, $past(reset), !rsp_valid && !req_stall)

   // A stalled result holds
   `BDA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))

   // After an accepted transaction the output always holds a valid result next cycle
   `BDA_ASSERT(a_accept_result, clock, reset, req_valid && !req_stall |=> rsp_valid)

endmodule

bind button_debounce_autorepeat_core bda_checker u_bda_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
